>>> sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg - shared types and constants of the DDA line rasterizer
// Field widths, opcode, controller states and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int IN_W    = 20;              // start/end coordinate width
  localparam int COUNT_W = 13;              // pixel count width
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam int ROOT_W  = IN_W + 1;        // width of |delta| and of the root
  localparam int RAD_W   = 2 * ROOT_W;      // width of dx*dx + dy*dy

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_READY,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_CHECK,
    ST_DIVX,
    ST_DIVY_LOAD,
    ST_DIVY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic cap_line;
    logic do_square;
    logic do_sum;
    logic sqrt_iter;
    logic div_load_x;
    logic div_load_y;
    logic div_iter;
    logic store_step_x;
    logic emit_step;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
  } dp_status_t;

endpackage

>>> sv/dda_controller.sv
// ----------------------------------------------------------------------------
// dda_controller - sequencer of the DDA line rasterizer
// Runs the load sequence (squares, bit-serial root, two divisions) and the pixel
// steps, owns the iteration counter and the valid flag of the output register.
// ----------------------------------------------------------------------------
module dda_controller #(
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_opcode,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  dda_pkg::dp_status_t status,
  output dda_pkg::dp_cmd_t    cmd
);

  localparam int NUM_W = dda_pkg::ROOT_W + STEP_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  dda_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_READY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      dda_pkg::ST_READY: begin
        in_tready = slot_free;
        if (in_tvalid && slot_free) begin
          if (dda_pkg::opcode_t'(in_opcode) == dda_pkg::OP_STEP) begin
            cmd.emit_step = 1'b1;
          end else begin
            cmd.cap_line = 1'b1;
            state_nxt    = dda_pkg::ST_SQUARE;
          end
        end
      end
      dda_pkg::ST_SQUARE: begin
        cmd.do_square = 1'b1;
        state_nxt     = dda_pkg::ST_SUM;
      end
      dda_pkg::ST_SUM: begin
        cmd.do_sum = 1'b1;
        cnt_nxt    = CNT_W'(dda_pkg::ROOT_W - 1);
        state_nxt  = dda_pkg::ST_SQRT;
      end
      dda_pkg::ST_SQRT: begin
        cmd.sqrt_iter = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = dda_pkg::ST_CHECK;
        end
      end
      dda_pkg::ST_CHECK: begin
        // zero-length line: skip both divisions
        if (status.count_zero) begin
          state_nxt = dda_pkg::ST_FINISH;
        end else begin
          cmd.div_load_x = 1'b1;
          cnt_nxt        = CNT_W'(NUM_W - 1);
          state_nxt      = dda_pkg::ST_DIVX;
        end
      end
      dda_pkg::ST_DIVX: begin
        cmd.div_iter = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = dda_pkg::ST_DIVY_LOAD;
        end
      end
      dda_pkg::ST_DIVY_LOAD: begin
        cmd.store_step_x = 1'b1;
        cmd.div_load_y   = 1'b1;
        cnt_nxt          = CNT_W'(NUM_W - 1);
        state_nxt        = dda_pkg::ST_DIVY;
      end
      dda_pkg::ST_DIVY: begin
        cmd.div_iter = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = dda_pkg::ST_FINISH;
        end
      end
      dda_pkg::ST_FINISH: begin
        // hold until the output register can take the load result
        if (slot_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = dda_pkg::ST_READY;
        end
      end
      default: begin
        state_nxt = dda_pkg::ST_READY;
      end
    endcase

    if (cmd.emit_step || cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

>>> sv/dda_datapath.sv
// ----------------------------------------------------------------------------
// dda_datapath - arithmetic of the DDA line rasterizer
// Position and increment registers, squaring, bit-serial square root, a
// shared restoring divider and the output payload register.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int STEP_FRAC_BITS  = 16,
  parameter int PIXEL_BITS      = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dda_pkg::dp_cmd_t                    cmd,
  output dda_pkg::dp_status_t                 status,
  input  logic signed [dda_pkg::IN_W-1:0]     x_start,
  input  logic signed [dda_pkg::IN_W-1:0]     y_start,
  input  logic signed [dda_pkg::IN_W-1:0]     x_end,
  input  logic signed [dda_pkg::IN_W-1:0]     y_end,
  output logic signed [PIXEL_BITS-1:0]        pixel_x,
  output logic signed [PIXEL_BITS-1:0]        pixel_y,
  output logic                                pixel_valid,
  output logic                                last_pixel,
  output logic [dda_pkg::COUNT_W-1:0]         pixel_count
);

  localparam int IN_W    = dda_pkg::IN_W;
  localparam int COUNT_W = dda_pkg::COUNT_W;
  localparam int ROOT_W  = dda_pkg::ROOT_W;
  localparam int RAD_W   = dda_pkg::RAD_W;
  localparam int D_W     = IN_W + 1;
  localparam int LSH     = (STEP_FRAC_BITS >= COORD_FRAC_BITS) ?
                           STEP_FRAC_BITS - COORD_FRAC_BITS : 0;
  localparam int RSH     = (COORD_FRAC_BITS > STEP_FRAC_BITS) ?
                           COORD_FRAC_BITS - STEP_FRAC_BITS : 0;
  localparam int POS_W   = IN_W + 1 + LSH;
  localparam int NUM_W   = D_W + STEP_FRAC_BITS;
  localparam int DEN_W   = COUNT_W + COORD_FRAC_BITS;

  localparam logic signed [POS_W-1:0] POS_RND = POS_W'((1 << RSH) - 1);
  localparam logic signed [POS_W-1:0] PIX_RND =
    {{(POS_W-STEP_FRAC_BITS){1'b0}}, {STEP_FRAC_BITS{1'b1}}};

  // start coordinate to position, truncated toward zero
  function automatic logic signed [POS_W-1:0] to_pos(input logic signed [IN_W-1:0] c);
    logic signed [POS_W-1:0] ext;
    ext = POS_W'(c);
    ext = ext + (c[IN_W-1] ? POS_RND : '0);
    return (ext >>> RSH) <<< LSH;
  endfunction

  // position to whole pixels, truncated toward zero, wrapped to PIXEL_BITS
  function automatic logic signed [PIXEL_BITS-1:0] to_pixel(
    input logic signed [POS_W-1:0] p
  );
    logic signed [POS_W-1:0] t;
    t = p + (p[POS_W-1] ? PIX_RND : '0);
    t = t >>> STEP_FRAC_BITS;
    return t[PIXEL_BITS-1:0];
  endfunction

  logic signed [POS_W-1:0]   pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [POS_W-1:0]   step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [COUNT_W-1:0]        remaining_r, remaining_nxt;
  logic [D_W-1:0]            adx_r, adx_nxt, ady_r, ady_nxt;
  logic                      sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic [RAD_W-1:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [ROOT_W+1:0]         rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [NUM_W-1:0]          nq_r, nq_nxt;
  logic [DEN_W-1:0]          drem_r, drem_nxt;
  logic                      dneg_r, dneg_nxt;
  logic signed [PIXEL_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                      pv_r, pv_nxt, last_r, last_nxt;
  logic [COUNT_W-1:0]        cnt_out_r, cnt_out_nxt;

  logic signed [D_W-1:0]     dx, dy;
  logic [ROOT_W+3:0]         sq_tmp, sq_trial;
  logic [ROOT_W-1:0]         sqrt_len;
  logic [COUNT_W-1:0]        count;
  logic [DEN_W-1:0]          den;
  logic [DEN_W:0]            div_tmp;
  logic [POS_W-1:0]          q_mag;
  logic signed [POS_W-1:0]   quot;

  assign dx = D_W'(x_end) - D_W'(x_start);
  assign dy = D_W'(y_end) - D_W'(y_start);

  assign sqrt_len = root_r >> COORD_FRAC_BITS;
  assign count    = (sqrt_len > ROOT_W'(dda_pkg::COUNT_MAX)) ? dda_pkg::COUNT_MAX :
                    sqrt_len[COUNT_W-1:0];
  assign status.count_zero = (count == '0);

  assign den      = DEN_W'(count) << COORD_FRAC_BITS;
  assign div_tmp  = {drem_r, nq_r[NUM_W-1]};
  assign sq_tmp   = {2'b00, rem_r} << 2 | (ROOT_W+4)'(rad_r[RAD_W-1 -: 2]);
  assign sq_trial = (ROOT_W+4)'({root_r, 2'b01});
  assign q_mag    = nq_r[POS_W-1:0];
  assign quot     = dneg_r ? -$signed(q_mag) : $signed(q_mag);

  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    remaining_nxt = remaining_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    nq_nxt        = nq_r;
    drem_nxt      = drem_r;
    dneg_nxt      = dneg_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pv_nxt        = pv_r;
    last_nxt      = last_r;
    cnt_out_nxt   = cnt_out_r;

    if (cmd.cap_line) begin
      pos_x_nxt  = to_pos(x_start);
      pos_y_nxt  = to_pos(y_start);
      sx_neg_nxt = dx[D_W-1];
      sy_neg_nxt = dy[D_W-1];
      adx_nxt    = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
      ady_nxt    = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    end

    if (cmd.do_square) begin
      sqx_nxt = adx_r * adx_r;
      sqy_nxt = ady_r * ady_r;
    end

    if (cmd.do_sum) begin
      rad_nxt  = sqx_r + sqy_r;
      rem_nxt  = '0;
      root_nxt = '0;
    end

    // one root bit per cycle, two radicand bits in
    if (cmd.sqrt_iter) begin
      rad_nxt = rad_r << 2;
      if (sq_tmp >= sq_trial) begin
        rem_nxt  = (ROOT_W+2)'(sq_tmp - sq_trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sq_tmp[ROOT_W+1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd.div_load_x) begin
      nq_nxt   = NUM_W'(adx_r) << STEP_FRAC_BITS;
      drem_nxt = '0;
      dneg_nxt = sx_neg_r;
    end

    if (cmd.div_load_y) begin
      nq_nxt   = NUM_W'(ady_r) << STEP_FRAC_BITS;
      drem_nxt = '0;
      dneg_nxt = sy_neg_r;
    end

    // restoring division, quotient bits shift in behind the numerator
    if (cmd.div_iter) begin
      if (div_tmp >= {1'b0, den}) begin
        drem_nxt = DEN_W'(div_tmp - {1'b0, den});
        nq_nxt   = {nq_r[NUM_W-2:0], 1'b1};
      end else begin
        drem_nxt = div_tmp[DEN_W-1:0];
        nq_nxt   = {nq_r[NUM_W-2:0], 1'b0};
      end
    end

    if (cmd.store_step_x) begin
      step_x_nxt = quot;
    end

    if (cmd.emit_load) begin
      remaining_nxt = count;
      if (status.count_zero) begin
        step_x_nxt = '0;
        step_y_nxt = '0;
      end else begin
        step_y_nxt = quot;
      end
      px_nxt      = '0;
      py_nxt      = '0;
      pv_nxt      = 1'b0;
      last_nxt    = 1'b0;
      cnt_out_nxt = count;
    end

    if (cmd.emit_step) begin
      cnt_out_nxt = '0;
      if (remaining_r != '0) begin
        px_nxt        = to_pixel(pos_x_r);
        py_nxt        = to_pixel(pos_y_r);
        pv_nxt        = 1'b1;
        last_nxt      = (remaining_r == COUNT_W'(1));
        pos_x_nxt     = pos_x_r + step_x_r;
        pos_y_nxt     = pos_y_r + step_y_r;
        remaining_nxt = remaining_r - 1'b1;
      end else begin
        px_nxt   = '0;
        py_nxt   = '0;
        pv_nxt   = 1'b0;
        last_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
    end else begin
      remaining_r <= remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    step_x_r  <= step_x_nxt;
    step_y_r  <= step_y_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    sx_neg_r  <= sx_neg_nxt;
    sy_neg_r  <= sy_neg_nxt;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    nq_r      <= nq_nxt;
    drem_r    <= drem_nxt;
    dneg_r    <= dneg_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pv_r      <= pv_nxt;
    last_r    <= last_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign pixel_valid = pv_r;
  assign last_pixel  = last_r;
  assign pixel_count = cnt_out_r;

endmodule

>>> sv/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer - DDA line rasterizer, top level
// Load a segment, report its pixel count, then emit one pixel per request.
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------------
//   in_*     | slave     | tuser: opcode; tdata: x_start,y_start,x_end,y_end
//   out_*    | master    | tuser: pixel_valid; tlast: last_pixel;
//            |           | tdata: pixel_x,pixel_y,pixel_count
//
// Pixel requests stream back to back while the output register can take them.
// A load result is computed by the bit-serial square root and then the single
// restoring divider, run once per axis (both divisions are skipped for a
// zero-length line); no new request is taken until the result has been
// written to the output register.
// Reset (rst_n low, synchronous) leaves the block idle with no line loaded.
// When idle, the input is free whenever the output register is empty or out_tready is high.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int STEP_FRAC_BITS  = 16,
  parameter int PIXEL_BITS      = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [4*dda_pkg::IN_W-1:0] in_tdata,   // x_start, y_start, x_end, y_end
  input  logic                 in_tuser,         // opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((2*PIXEL_BITS+dda_pkg::COUNT_W+7)/8)*8-1:0] out_tdata,
                                                 // pixel_x, pixel_y, pixel_count
  output logic                 out_tuser,        // pixel_valid
  output logic                 out_tlast         // last_pixel
);

  localparam int IN_W       = dda_pkg::IN_W;
  localparam int OUT_DATA_W = ((2*PIXEL_BITS+dda_pkg::COUNT_W+7)/8)*8;

  dda_pkg::dp_cmd_t             cmd;
  dda_pkg::dp_status_t          status;
  logic signed [PIXEL_BITS-1:0] pixel_x, pixel_y;
  logic [dda_pkg::COUNT_W-1:0]  pixel_count;

  dda_controller #(
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  dda_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .STEP_FRAC_BITS  (STEP_FRAC_BITS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .x_start     ($signed(in_tdata[IN_W-1:0])),
    .y_start     ($signed(in_tdata[2*IN_W-1:IN_W])),
    .x_end       ($signed(in_tdata[3*IN_W-1:2*IN_W])),
    .y_end       ($signed(in_tdata[4*IN_W-1:3*IN_W])),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (out_tuser),
    .last_pixel  (out_tlast),
    .pixel_count (pixel_count)
  );

  assign out_tdata = OUT_DATA_W'({pixel_count, pixel_y, pixel_x});

endmodule

>>> sim/dda_line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb - self-checking bench for the DDA line rasterizer
// Drives load and pixel requests with random gaps and output stalls. Every
// accepted request is run through a fixed-point line model kept in the bench.
// Each returned pixel or count is then checked against the oldest prediction.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

  localparam int IN_W        = dda_pkg::IN_W;
  localparam int COUNT_W     = dda_pkg::COUNT_W;
  localparam int COORD_FRAC  = 8;
  localparam int STEP_FRAC   = 16;
  localparam int PIXEL_W     = 12;
  localparam int OUT_W       = ((2 * PIXEL_W + COUNT_W + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1050;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int COORD_MAX   = 524287;
  localparam int COORD_MIN   = -524288;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] pixel_x;
    logic signed [PIXEL_W-1:0] pixel_y;
    logic                      pixel_valid;
    logic                      last_pixel;
    logic [COUNT_W-1:0]        pixel_count;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [4*IN_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // line model state
  longint                line_pos_x, line_pos_y;
  longint                line_step_x, line_step_y;
  int unsigned           pixels_left;

  pixel_result_t         pending_pixels[$];
  int                    errors;
  int                    items_sent;
  int                    n_loads, n_zero_loads, n_steps, n_pixels, n_lines_done;
  int                    cycle_count;
  bit                    no_idle;
  int                    ready_hold;

  dda_line_rasterizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint root, trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [IN_W-1:0] to_coord(int v);
    return IN_W'(v);
  endfunction

  function automatic logic signed [IN_W-1:0] offset_coord(int base, int delta);
    int v;
    v = base + delta;
    // reflect the offset rather than leave the coordinate range
    if (v > COORD_MAX || v < COORD_MIN) v = base - delta;
    return to_coord(v);
  endfunction

  function automatic pixel_result_t predict_pixel(dda_pkg::opcode_t op,
      logic signed [IN_W-1:0] xs, logic signed [IN_W-1:0] ys,
      logic signed [IN_W-1:0] xe, logic signed [IN_W-1:0] ye);
    pixel_result_t r;
    longint dx, dy, len, den;
    r = '0;
    if (op == dda_pkg::OP_LOAD) begin
      dx  = longint'(xe) - longint'(xs);
      dy  = longint'(ye) - longint'(ys);
      len = floor_sqrt(dx * dx + dy * dy) >>> COORD_FRAC;
      if (len > longint'(dda_pkg::COUNT_MAX)) len = longint'(dda_pkg::COUNT_MAX);
      line_pos_x = longint'(xs) * (64'sd1 << STEP_FRAC) / (64'sd1 << COORD_FRAC);
      line_pos_y = longint'(ys) * (64'sd1 << STEP_FRAC) / (64'sd1 << COORD_FRAC);
      if (len != 0) begin
        den = len * (64'sd1 << COORD_FRAC);
        line_step_x = dx * (64'sd1 << STEP_FRAC) / den;
        line_step_y = dy * (64'sd1 << STEP_FRAC) / den;
      end else begin
        line_step_x = 0;
        line_step_y = 0;
        n_zero_loads++;
      end
      pixels_left   = 32'(len);
      r.pixel_count = COUNT_W'(len);
      n_loads++;
    end else begin
      n_steps++;
      if (pixels_left != 0) begin
        // truncate toward zero, then wrap to the pixel width
        r.pixel_x     = PIXEL_W'(line_pos_x / (64'sd1 << STEP_FRAC));
        r.pixel_y     = PIXEL_W'(line_pos_y / (64'sd1 << STEP_FRAC));
        r.pixel_valid = 1'b1;
        r.last_pixel  = (pixels_left == 1);
        line_pos_x   += line_step_x;
        line_pos_y   += line_step_y;
        pixels_left--;
      end
    end
    return r;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_request(dda_pkg::opcode_t op, logic signed [IN_W-1:0] xs,
      logic signed [IN_W-1:0] ys, logic signed [IN_W-1:0] xe,
      logic signed [IN_W-1:0] ye);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {ye, xe, ys, xs};
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(predict_pixel(op, xs, ys, xe, ye));
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_steps(int n);
    repeat (n) send_request(dda_pkg::OP_STEP, to_coord(int'($urandom)),
                            to_coord(int'($urandom)), to_coord(int'($urandom)),
                            to_coord(int'($urandom)));
  endtask

  task automatic wait_drain();
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      errors++;
    end
  endtask

  initial begin
    out_tready = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        ready_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: tdata=%h tuser=%b tlast=%b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        check_field("pixel_x", int'(exp_px.pixel_x),
                    int'($signed(out_tdata[PIXEL_W-1:0])));
        check_field("pixel_y", int'(exp_px.pixel_y),
                    int'($signed(out_tdata[2*PIXEL_W-1:PIXEL_W])));
        check_field("pixel_valid", int'(exp_px.pixel_valid), int'(out_tuser));
        check_field("last_pixel", int'(exp_px.last_pixel), int'(out_tlast));
        check_field("pixel_count", int'(exp_px.pixel_count),
                    int'(out_tdata[2*PIXEL_W+COUNT_W-1:2*PIXEL_W]));
        if (exp_px.pixel_valid) n_pixels++;
        if (exp_px.last_pixel) n_lines_done++;
      end
    end
  end

  task automatic test_idle_steps();
    send_steps(2);
  endtask

  task automatic test_zero_length();
    send_request(dda_pkg::OP_LOAD, to_coord(COORD_MIN), to_coord(COORD_MAX),
                 to_coord(COORD_MIN), to_coord(COORD_MAX));
    send_request(dda_pkg::OP_LOAD, to_coord(300), to_coord(-300), to_coord(350),
                 to_coord(-250));
    send_steps(1);
  endtask

  task automatic test_short_lines();
    // single pixel, then a step past the end
    send_request(dda_pkg::OP_LOAD, to_coord(0), to_coord(0), to_coord(300),
                 to_coord(0));
    send_steps(2);
    // negative start: truncation toward zero
    send_request(dda_pkg::OP_LOAD, to_coord(-384), to_coord(-128), to_coord(-896),
                 to_coord(-640));
    send_steps(3);
    send_request(dda_pkg::OP_LOAD, to_coord(1000), to_coord(-2000), to_coord(1000),
                 to_coord(1200));
    send_steps(5);
  endtask

  task automatic test_extreme_line();
    send_request(dda_pkg::OP_LOAD, to_coord(COORD_MIN), to_coord(COORD_MIN),
                 to_coord(COORD_MAX), to_coord(COORD_MAX));
    send_steps(3);
    // abandon the line mid-way
    send_request(dda_pkg::OP_LOAD, to_coord(COORD_MAX), to_coord(COORD_MIN),
                 to_coord(COORD_MIN), to_coord(COORD_MAX));
    send_steps(2);
    wait_drain();
  endtask

  task automatic test_random_lines();
    int kind, steps, dmax;
    logic signed [IN_W-1:0] xs, ys;
    while (items_sent < ITEM_TARGET) begin
      kind    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 4) == 0);
      xs      = to_coord(int'($urandom));
      ys      = to_coord(int'($urandom));
      if (kind < 5) begin
        send_steps(1);
      end else if (kind < 8) begin
        send_request(dda_pkg::OP_LOAD, xs, ys,
                     to_coord(xs + int'($urandom_range(0, 100))), ys);
      end else if (kind < 18) begin
        send_request(dda_pkg::OP_LOAD, xs, ys, to_coord(int'($urandom)),
                     to_coord(int'($urandom)));
        send_steps(int'($urandom_range(1, 20)));
      end else begin
        dmax = 24 << COORD_FRAC;
        send_request(dda_pkg::OP_LOAD, xs, ys,
                     offset_coord(xs, int'($urandom_range(0, 2 * dmax)) - dmax),
                     offset_coord(ys, int'($urandom_range(0, 2 * dmax)) - dmax));
        steps = int'(pixels_left) + int'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) steps = int'(pixels_left / 2);
        send_steps(steps);
      end
      if ($urandom_range(0, 29) == 0) wait_drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = dda_pkg::OP_LOAD;
    in_tdata    = '0;
    no_idle     = 1'b0;
    errors      = 0;
    items_sent  = 0;
    cycle_count = 0;
    pixels_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_steps();
    test_zero_length();
    test_short_lines();
    test_extreme_line();
    test_random_lines();

    wait_drain();
    repeat (20) @(negedge clk);
    $display("Ran %0d line loads (%0d of zero length) and %0d pixel requests.",
             n_loads, n_zero_loads, n_steps);
    $display("Checked %0d emitted pixels; %0d lines were followed to their last pixel.",
             n_pixels, n_lines_done);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
